/* src/sfac_pkg.sv */
// ----------------------------------------------------------------------------
// sfac_pkg: shared types and constants for the screen fade alpha controller
// Beat payloads, phase and command codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sfac_pkg;

  localparam int unsigned DUR_W   = 16;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned QUO_W   = 8;

  localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'hFF;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_FADE_IN    = 2'd1,
    CMD_FADE_OUT   = 2'd2,
    CMD_SET_STATUS = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_COVERED  = 2'd0,
    PH_CLEAR    = 2'd1,
    PH_FADE_IN  = 2'd2,
    PH_FADE_OUT = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [DUR_W-1:0]   duration;
    logic               target_status;
    logic [DELAY_W-1:0] delay;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               draw;
    logic               accepted;
    logic [1:0]         fade_state;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic div_init;
    logic div_step;
    logic finish;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic fade_tick;
  } ctl_status_t;

endpackage

/* src/sfac_ctrl.sv */
// ----------------------------------------------------------------------------
// sfac_ctrl: sequencing state machine
// Walks each beat through apply, the serial divide for fade ticks and the
// hand-off into the result register; owns the result valid flag.
// ----------------------------------------------------------------------------
module sfac_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  output logic                   result_valid,
  input  logic                   result_ready,
  output sfac_pkg::ctl_cmd_t     cmd,
  input  sfac_pkg::ctl_status_t  status
);

  localparam int unsigned STEP_W = $clog2(sfac_pkg::QUO_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(sfac_pkg::QUO_W - 1);

  sfac_pkg::ctrl_state_t state;
  sfac_pkg::ctrl_state_t state_next;
  logic [STEP_W-1:0]     step;
  logic                  slot_free;

  assign slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sfac_pkg::ST_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_init) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + 1'b1;
      end
      if (cmd.emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sfac_pkg::ST_IDLE: begin
        if (item_valid) state_next = sfac_pkg::ST_APPLY;
      end
      sfac_pkg::ST_APPLY: begin
        state_next = status.fade_tick ? sfac_pkg::ST_DIV_INIT : sfac_pkg::ST_EMIT;
      end
      sfac_pkg::ST_DIV_INIT: begin
        state_next = sfac_pkg::ST_DIV;
      end
      sfac_pkg::ST_DIV: begin
        if (step == LAST_STEP) state_next = sfac_pkg::ST_FINISH;
      end
      sfac_pkg::ST_FINISH: begin
        state_next = sfac_pkg::ST_EMIT;
      end
      sfac_pkg::ST_EMIT: begin
        if (slot_free) state_next = sfac_pkg::ST_IDLE;
      end
      default: begin
        state_next = sfac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    item_ready   = 1'b0;
    cmd          = '0;
    case (state)
      sfac_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      sfac_pkg::ST_APPLY:    cmd.apply    = 1'b1;
      sfac_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      sfac_pkg::ST_DIV:      cmd.div_step = 1'b1;
      sfac_pkg::ST_FINISH:   cmd.finish   = 1'b1;
      sfac_pkg::ST_EMIT:     cmd.emit     = slot_free;
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

/* src/sfac_datapath.sv */
// ----------------------------------------------------------------------------
// sfac_datapath: fade state, delay counter and serial ratio divider
// Holds the phase and counters, applies each command, forms
// tick*255/length one quotient bit a cycle and loads the result register.
// ----------------------------------------------------------------------------
module sfac_datapath #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfac_pkg::item_t       item,
  input  sfac_pkg::ctl_cmd_t    cmd,
  output sfac_pkg::ctl_status_t status,
  output sfac_pkg::result_t     result
);

  localparam int unsigned PROD_W = COUNT_BITS + sfac_pkg::ALPHA_W;

  sfac_pkg::item_t  item_r;
  sfac_pkg::phase_t phase;
  logic             pending_phase;
  logic             delay_active;
  logic [sfac_pkg::DELAY_W-1:0] delay_count;
  logic [COUNT_BITS-1:0]        tick_count;
  logic [COUNT_BITS-1:0]        fade_length;
  logic [sfac_pkg::ALPHA_W-1:0] opacity;
  logic             draw_flag;
  logic             acc_flag;

  // divider
  logic [COUNT_BITS-1:0]      rem;
  logic [sfac_pkg::QUO_W-1:0] low_bits;
  logic [sfac_pkg::QUO_W-1:0] quo;
  logic                       sat;

  // tick-time view of the state after any pending phase change
  sfac_pkg::phase_t             ph_eff;
  logic                         delay_active_next;
  logic [sfac_pkg::DELAY_W-1:0] delay_count_next;

  logic [COUNT_BITS+sfac_pkg::DUR_W-1:0] dur_ext;
  logic [PROD_W-1:0]                     prod;
  logic [COUNT_BITS:0]                   trial;
  logic [COUNT_BITS:0]                   diff;
  logic [sfac_pkg::ALPHA_W-1:0]          ratio;
  logic [sfac_pkg::ALPHA_W-1:0]          fade_alpha;
  sfac_pkg::cmd_t                        cmd_code;
  logic                                  is_fade;

  assign cmd_code = sfac_pkg::cmd_t'(item_r.command);
  assign dur_ext  = {{COUNT_BITS{1'b0}}, item_r.duration};

  always_comb begin
    ph_eff            = phase;
    delay_active_next = delay_active;
    delay_count_next  = delay_count;
    if (delay_active) begin
      if (delay_count == '0) begin
        ph_eff            = sfac_pkg::phase_t'({1'b0, pending_phase});
        delay_active_next = 1'b0;
      end else begin
        delay_count_next = delay_count - 1'b1;
      end
    end
  end

  assign is_fade = (ph_eff == sfac_pkg::PH_FADE_IN) || (ph_eff == sfac_pkg::PH_FADE_OUT);
  assign status.fade_tick = (cmd_code == sfac_pkg::CMD_TICK) && is_fade;

  // tick*255 as (tick << 8) - tick
  assign prod  = {tick_count, {sfac_pkg::ALPHA_W{1'b0}}}
               - {{sfac_pkg::ALPHA_W{1'b0}}, tick_count};
  assign trial = {rem, low_bits[sfac_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, fade_length};

  assign ratio      = sat ? sfac_pkg::FULL_ALPHA : quo;
  assign fade_alpha = (phase == sfac_pkg::PH_FADE_IN) ? (sfac_pkg::FULL_ALPHA - ratio) : ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= sfac_pkg::PH_COVERED;
      pending_phase <= 1'b0;
      delay_active  <= 1'b0;
      delay_count   <= '0;
      tick_count    <= '0;
      fade_length   <= '0;
      opacity       <= sfac_pkg::FULL_ALPHA;
    end else begin
      if (cmd.apply) begin
        case (cmd_code)
          sfac_pkg::CMD_TICK: begin
            delay_active <= delay_active_next;
            delay_count  <= delay_count_next;
            phase        <= ph_eff;
            if (ph_eff == sfac_pkg::PH_COVERED) begin
              opacity <= sfac_pkg::FULL_ALPHA;
            end
            if (is_fade) begin
              tick_count <= tick_count + 1'b1;
            end
          end
          sfac_pkg::CMD_FADE_IN: begin
            if (phase == sfac_pkg::PH_COVERED) begin
              phase       <= sfac_pkg::PH_FADE_IN;
              tick_count  <= '0;
              fade_length <= dur_ext[COUNT_BITS-1:0];
            end
          end
          sfac_pkg::CMD_FADE_OUT: begin
            if (phase == sfac_pkg::PH_CLEAR) begin
              phase       <= sfac_pkg::PH_FADE_OUT;
              tick_count  <= '0;
              fade_length <= dur_ext[COUNT_BITS-1:0];
            end
          end
          sfac_pkg::CMD_SET_STATUS: begin
            pending_phase <= item_r.target_status;
            delay_active  <= 1'b1;
            if (item_r.delay != '0) begin
              delay_count <= item_r.delay;
            end else begin
              phase       <= sfac_pkg::phase_t'({1'b0, item_r.target_status});
              delay_count <= '0;
            end
          end
          default: begin
            phase <= phase;
          end
        endcase
      end
      if (cmd.finish) begin
        opacity <= fade_alpha;
        if (sat) begin
          phase <= (phase == sfac_pkg::PH_FADE_IN) ? sfac_pkg::PH_CLEAR
                                                   : sfac_pkg::PH_COVERED;
        end
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= item;
    end
    if (cmd.apply) begin
      acc_flag  <= ((cmd_code == sfac_pkg::CMD_FADE_IN) && (phase == sfac_pkg::PH_COVERED))
                || ((cmd_code == sfac_pkg::CMD_FADE_OUT) && (phase == sfac_pkg::PH_CLEAR));
      draw_flag <= (cmd_code == sfac_pkg::CMD_TICK) && (ph_eff == sfac_pkg::PH_COVERED);
    end
    if (cmd.div_init) begin
      // tick >= length saturates the ratio, length zero included
      sat      <= (tick_count >= fade_length);
      rem      <= prod[PROD_W-1:sfac_pkg::ALPHA_W];
      low_bits <= prod[sfac_pkg::ALPHA_W-1:0];
      quo      <= '0;
    end
    if (cmd.div_step) begin
      if (!diff[COUNT_BITS]) begin
        rem <= diff[COUNT_BITS-1:0];
      end else begin
        rem <= trial[COUNT_BITS-1:0];
      end
      low_bits <= {low_bits[sfac_pkg::QUO_W-2:0], 1'b0};
      quo      <= {quo[sfac_pkg::QUO_W-2:0], ~diff[COUNT_BITS]};
    end
    if (cmd.finish) begin
      draw_flag <= (fade_alpha != '0);
    end
    if (cmd.emit) begin
      result.alpha      <= opacity;
      result.draw       <= draw_flag;
      result.accepted   <= acc_flag;
      result.fade_state <= phase;
    end
  end

endmodule

/* src/screen_fade_alpha_controller.sv */
// ----------------------------------------------------------------------------
// screen_fade_alpha_controller: overlay fade phase and alpha generator
// Takes one command beat at a time (tick, start fade in, start fade out,
// set status) and returns exactly one result beat for each.
//
// Channels: item_valid/item_ready/item in, result_valid/result_ready/result
// out, both plain valid/ready; a beat moves when valid and ready are high.
// Sequence: a non-fade beat passes through apply and emit after acceptance;
// a tick in a fade phase also runs divider init, the restoring divider and
// finish, the divider forming tick*255/length one quotient bit a cycle.
// Flow: one beat in flight; a new beat is taken as soon as the previous
// result is in the output register.
// Reset: synchronous, returns to the covered phase with alpha 255 and no
// delayed change armed.
// Stall: a held result keeps the output register; the next beat is still
// accepted and runs up to its hand-off, where it waits for the slot.
// ----------------------------------------------------------------------------
module screen_fade_alpha_controller #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  sfac_pkg::item_t    item,
  output logic               result_valid,
  input  logic               result_ready,
  output sfac_pkg::result_t  result
);

  sfac_pkg::ctl_cmd_t    cmd;
  sfac_pkg::ctl_status_t status;

  sfac_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd),
    .status       (status)
  );

  sfac_datapath #(
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule
